### hw/rtl/wnq_pkg.sv
// ----------------------------------------------------------------------------
// wnq_pkg
// Types, constants and helpers shared by the winding number quadrant block.
// ----------------------------------------------------------------------------
package wnq_pkg;

    // Coordinate bits actually used; fields are 32 bits and are sign extended
    // from bit COORD_WIDTH-1.
    localparam int COORD_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int ACC_W       = 15;
    localparam int WIND_W      = 13;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ON_POINT = 2'd1;
    localparam logic [1:0] ST_ON_EDGE  = 2'd2;

    // Register indexes
    localparam logic REG_POINT_X = 1'b0;
    localparam logic REG_POINT_Y = 1'b1;

    // What the edge ending at a vertex contributes
    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_INC,
        STEP_DEC,
        STEP_CROSS,
        STEP_ON_POINT
    } t_step;

    typedef struct packed {
        logic signed [FIELD_W-1:0] vertex_x;
        logic signed [FIELD_W-1:0] vertex_y;
        logic                      last_vertex;
    } t_in;

    typedef struct packed {
        logic signed [WIND_W-1:0] winding_number;
        logic [1:0]               status;
    } t_out;

    function automatic logic signed [DIFF_W-1:0] sext_coord(logic [FIELD_W-1:0] v);
        logic signed [COORD_WIDTH-1:0] c;
        c = v[COORD_WIDTH-1:0];
        return DIFF_W'(c);
    endfunction

endpackage

### hw/rtl/winding_number_quadrant.sv
// ----------------------------------------------------------------------------
// winding_number_quadrant
// Quadrant counting winding number of a streamed contour around a point.
// ----------------------------------------------------------------------------
// Vertices enter one per cycle unless stalled and pass four registers:
// input, coordinate differences and quadrant, the two cross-product terms,
// and the result register. A contour result is registered when its last
// vertex retires from the product stage. While a result waits on the output
// stall, a following last vertex holds in the product stage and the input
// backs up behind it. The cross-product stage (two signed 33 x 33
// multiplies) sets the clock period. Each vertex is given a
// quadrant around (point_x, point_y); adjacent moves add +-1, opposite moves
// add +-2 by the cross-product sign, and the last vertex emits the saturated
// sum divided by 4 (toward zero) with a status, then clears the contour state.
// The point may be rewritten between vertices while nothing is in flight.
module winding_number_quadrant (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wnq_pkg::t_in       i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wnq_pkg::t_out      o_out_data
);
    import wnq_pkg::*;

    // configuration
    logic signed [DIFF_W-1:0] r_px, r_py;

    // stage 1: input register
    logic                     r_s1_valid;
    t_in                      r_s1;

    // stage 2: differences and edge kind
    logic                     r_s2_valid;
    logic                     r_s2_last;
    t_step                    r_s2_step;
    logic signed [DIFF_W-1:0] r_s2_dx, r_s2_dy, r_s2_pdx, r_s2_pdy;

    // stage 3: cross-product terms
    logic                     r_s3_valid;
    logic                     r_s3_last;
    t_step                    r_s3_step;
    logic signed [PROD_W-1:0] r_s3_p1, r_s3_p2;

    // previous vertex of the contour
    logic signed [DIFF_W-1:0] r_prev_x, r_prev_y;
    logic [1:0]               r_prev_q;
    logic                     r_have_prev;

    // contour accumulation
    logic signed [ACC_W-1:0]  r_acc;
    logic [1:0]               r_err;

    // result register
    logic                     r_out_valid;
    t_out                     r_out;

    logic adv1, adv2, adv3, out_free, move2, retire3;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv3       = !r_s3_valid || !r_s3_last || out_free;
    assign adv2       = !r_s2_valid || adv3;
    assign adv1       = !r_s1_valid || adv2;
    assign move2      = r_s1_valid && adv2;
    assign retire3    = r_s3_valid && adv3;
    assign o_in_stall = !adv1;

    // ---- stage 1 -> 2: differences, quadrant, edge kind ----
    logic signed [DIFF_W-1:0] n_x, n_y, n_dx, n_dy, n_pdx, n_pdy;
    logic [1:0]               n_q, n_dq;
    logic                     n_on_point;
    t_step                    n_step;

    always_comb begin
        n_x        = sext_coord(r_s1.vertex_x);
        n_y        = sext_coord(r_s1.vertex_y);
        n_dx       = n_x - r_px;
        n_dy       = n_y - r_py;
        n_pdx      = r_prev_x - r_px;
        n_pdy      = r_prev_y - r_py;
        n_on_point = 1'b0;
        priority if (n_dx > 0 && n_dy >= 0) begin
            n_q = 2'd0;
        end else if (n_dx <= 0 && n_dy > 0) begin
            n_q = 2'd1;
        end else if (n_dx < 0 && n_dy <= 0) begin
            n_q = 2'd2;
        end else if (n_dx >= 0 && n_dy < 0) begin
            n_q = 2'd3;
        end else begin
            n_q        = 2'd0;
            n_on_point = 1'b1;
        end
        n_dq = n_q - r_prev_q;
        priority if (n_on_point) begin
            n_step = STEP_ON_POINT;
        end else if (!r_have_prev) begin
            n_step = STEP_NONE;
        end else begin
            unique case (n_dq)
                2'd1:    n_step = STEP_INC;
                2'd3:    n_step = STEP_DEC;
                2'd2:    n_step = STEP_CROSS;
                default: n_step = STEP_NONE;
            endcase
        end
    end

    // ---- stage 3 retire: accumulate and form result ----
    logic signed [2:0]       n_delta;
    logic [1:0]              n_err;
    logic signed [ACC_W:0]   n_sum;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W:0]   n_adj;
    t_out                    n_out;

    always_comb begin
        n_delta = 3'sd0;
        n_err   = r_err;
        unique case (r_s3_step)
            STEP_INC: n_delta = 3'sd1;
            STEP_DEC: n_delta = -3'sd1;
            STEP_CROSS: begin
                if (r_s3_p1 == r_s3_p2) begin
                    if (r_err == ST_OK) n_err = ST_ON_EDGE;
                end else if (r_s3_p1 > r_s3_p2) begin
                    n_delta = 3'sd2;
                end else begin
                    n_delta = -3'sd2;
                end
            end
            STEP_ON_POINT: begin
                if (r_err == ST_OK) n_err = ST_ON_POINT;
            end
            default: n_delta = 3'sd0;
        endcase
        n_sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'(n_delta);
        priority if (n_sum > (ACC_W+1)'(ACC_MAX)) begin
            n_acc = ACC_MAX;
        end else if (n_sum < (ACC_W+1)'(ACC_MIN)) begin
            n_acc = ACC_MIN;
        end else begin
            n_acc = n_sum[ACC_W-1:0];
        end
        // divide by 4 toward zero: bias negatives by 3 before the shift
        n_adj = (ACC_W+1)'(n_acc) + (n_acc[ACC_W-1] ? (ACC_W+1)'(3) : (ACC_W+1)'(0));
        n_out.status         = n_err;
        n_out.winding_number = (n_err == ST_OK) ? WIND_W'(n_adj >>> 2) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px        <= '0;
            r_py        <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_q    <= 2'd0;
            r_have_prev <= 1'b0;
            r_acc       <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_POINT_X: r_px <= sext_coord(i_cfg_data);
                    REG_POINT_Y: r_py <= sext_coord(i_cfg_data);
                    default:     r_px <= r_px;
                endcase
            end

            if (adv1) r_s1_valid <= i_in_valid;
            if (adv2) r_s2_valid <= r_s1_valid;
            if (adv3) r_s3_valid <= r_s2_valid;

            if (move2) begin
                if (r_s1.last_vertex) begin
                    r_prev_x    <= '0;
                    r_prev_y    <= '0;
                    r_prev_q    <= 2'd0;
                    r_have_prev <= 1'b0;
                end else begin
                    r_prev_x    <= n_x;
                    r_prev_y    <= n_y;
                    r_prev_q    <= n_q;
                    r_have_prev <= 1'b1;
                end
            end

            if (retire3) begin
                if (r_s3_last) begin
                    r_acc <= '0;
                    r_err <= ST_OK;
                end else begin
                    r_acc <= n_acc;
                    r_err <= n_err;
                end
            end

            if (retire3 && r_s3_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv1) r_s1 <= i_in_data;
        if (move2) begin
            r_s2_last <= r_s1.last_vertex;
            r_s2_step <= n_step;
            r_s2_dx   <= n_dx;
            r_s2_dy   <= n_dy;
            r_s2_pdx  <= n_pdx;
            r_s2_pdy  <= n_pdy;
        end
        if (r_s2_valid && adv3) begin
            r_s3_last <= r_s2_last;
            r_s3_step <= r_s2_step;
            r_s3_p1   <= PROD_W'(r_s2_pdx) * PROD_W'(r_s2_dy);
            r_s3_p2   <= PROD_W'(r_s2_dx) * PROD_W'(r_s2_pdy);
        end
        if (retire3 && r_s3_last) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_err_zero_wind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> o_out_data.winding_number == '0)
        else $error("winding number not zero on error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.status == ST_ON_POINT ||
                         o_out_data.status == ST_ON_EDGE))
        else $error("status code out of range");

    a_contour_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (retire3 && r_s3_last) |=> (r_acc == '0 && r_err == ST_OK && o_out_valid))
        else $error("contour state not cleared after last vertex");

    a_prev_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move2 && r_s1.last_vertex) |=> !r_have_prev)
        else $error("previous vertex kept across contours");

    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !adv3) |=> (r_s3_valid && $stable(r_s3_p1) && $stable(r_s3_step)))
        else $error("blocked stage lost its item");
`endif

endmodule
